>>> src/sacl_pkg.sv
// shared types and constants for the set-associative cache tag store
package sacl_pkg;

    localparam int SETS_DEFAULT = 256;
    localparam int WAYS_DEFAULT = 4;

    localparam int ADDRESS_W = 32;
    localparam int TAG_W     = 32;
    localparam int STAMP_W   = 32;
    localparam int MISS_W    = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAYS_USED   = 2'd2;

    localparam logic [4:0] OFFSET_BITS_RESET = 5'd4;
    localparam logic [3:0] INDEX_BITS_RESET  = 4'd8;
    localparam logic [2:0] WAYS_USED_RESET   = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } line_t;

endpackage

>>> src/sacl_line_ram.sv
// line memory holding valid bit, tag and timestamp of every way of every set
module sacl_line_ram #(
    parameter int DEPTH = sacl_pkg::SETS_DEFAULT * sacl_pkg::WAYS_DEFAULT,
    parameter int AW    = 10
) (
    input  logic            aclk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  sacl_pkg::line_t wdata,
    input  logic [AW-1:0]   raddr,
    output sacl_pkg::line_t rdata
);

    sacl_pkg::line_t mem [DEPTH];
    sacl_pkg::line_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/set_assoc_lru_cache_tags.sv
// set-associative cache tag store with timestamp lru replacement, top level
// each word passes LOOKUP, SCAN (until a hit or the last way in use) and WRITE, which registers m_tvalid
// a new word is taken only after WRITE, which waits for a free output; one way is read and compared per cycle
// reset: lines are invalidated by a sweep over all SETS * WAYS lines (1024 by default)
// during the sweep s_tready stays low; configuration writes are always taken
module set_assoc_lru_cache_tags #(
    parameter int SETS = sacl_pkg::SETS_DEFAULT,
    parameter int WAYS = sacl_pkg::WAYS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,   // address
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,   // hit, way_index, cold_fill, miss_total
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sacl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sacl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DEPTH   = SETS * WAYS;
    localparam int LINE_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int IDX_W   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int KMAX    = $clog2(SETS + 1) - 1;

    sacl_pkg::state_t state_reg, state_next;

    logic [4:0]                     offset_bits_reg;
    logic [3:0]                     index_bits_reg;
    logic [2:0]                     ways_used_reg;

    logic [LINE_AW-1:0]             clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]               set_reg, set_next;
    logic [sacl_pkg::TAG_W-1:0]     tag_reg, tag_next;
    logic [WAY_W-1:0]               way_reg, way_next;
    logic [WAY_W-1:0]               inv_way_reg, inv_way_next;
    logic                           have_inv_reg, have_inv_next;
    logic [WAY_W-1:0]               best_way_reg, best_way_next;
    logic [sacl_pkg::STAMP_W-1:0]   best_stamp_reg, best_stamp_next;
    logic                           have_best_reg, have_best_next;
    logic [WAY_W-1:0]               victim_reg, victim_next;
    logic                           hit_reg, hit_next;
    logic                           cold_reg, cold_next;
    logic [sacl_pkg::STAMP_W-1:0]   time_reg, time_next;
    logic [sacl_pkg::MISS_W-1:0]    miss_reg, miss_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_hit_reg, out_hit_next;
    logic [1:0]                     out_way_reg, out_way_next;
    logic                           out_cold_reg, out_cold_next;
    logic [sacl_pkg::MISS_W-1:0]    out_miss_reg, out_miss_next;

    logic                           ram_we;
    logic [LINE_AW-1:0]             ram_waddr;
    sacl_pkg::line_t                ram_wdata;
    logic [LINE_AW-1:0]             ram_raddr;
    sacl_pkg::line_t                ram_rdata;

    logic [3:0]                     eff_ib;
    logic [4:0]                     eff_ways;
    logic [WAY_W-1:0]               last_way;
    logic [31:0]                    baddr;
    logic [31:0]                    set_mask;
    logic                           in_fire;
    logic                           wr_fire;
    logic                           match;
    logic                           take_best;
    logic                           last;

    function automatic logic [LINE_AW-1:0] line_addr(input logic [WAY_W-1:0] way,
                                                     input logic [IDX_W-1:0] set);
        line_addr = LINE_AW'(way) * LINE_AW'(SETS) + LINE_AW'(set);
    endfunction

    sacl_line_ram #(
        .DEPTH (DEPTH),
        .AW    (LINE_AW)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg <= sacl_pkg::OFFSET_BITS_RESET;
            index_bits_reg  <= sacl_pkg::INDEX_BITS_RESET;
            ways_used_reg   <= sacl_pkg::WAYS_USED_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sacl_pkg::CFG_OFFSET_BITS: offset_bits_reg <= cfg_data[4:0];
                sacl_pkg::CFG_INDEX_BITS:  index_bits_reg  <= cfg_data[3:0];
                sacl_pkg::CFG_WAYS_USED:   ways_used_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        eff_ib = (index_bits_reg > 4'(KMAX)) ? 4'(KMAX) : index_bits_reg;
        if (ways_used_reg == 3'd0) begin
            eff_ways = 5'd1;
        end else if ({2'b00, ways_used_reg} > 5'(WAYS)) begin
            eff_ways = 5'(WAYS);
        end else begin
            eff_ways = {2'b00, ways_used_reg};
        end
        last_way = WAY_W'(eff_ways - 5'd1);
        baddr    = s_tdata >> offset_bits_reg;
        set_mask = (32'd1 << eff_ib) - 32'd1;
    end

    assign s_tready = (state_reg == sacl_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign wr_fire  = (state_reg == sacl_pkg::ST_WRITE) && (!out_valid_reg || m_tready);

    // way compare of the word read from the line memory
    always_comb begin
        match     = ram_rdata.valid && (ram_rdata.tag == tag_reg);
        take_best = ram_rdata.valid && (!have_best_reg || (ram_rdata.stamp < best_stamp_reg));
        last      = (way_reg == last_way);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sacl_pkg::ST_CLEAR: begin
                if (clr_addr_reg == LINE_AW'(DEPTH - 1)) begin
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    state_next = sacl_pkg::ST_LOOKUP;
                end
            end
            sacl_pkg::ST_LOOKUP: begin
                state_next = sacl_pkg::ST_SCAN;
            end
            sacl_pkg::ST_SCAN: begin
                if (match || last) begin
                    state_next = sacl_pkg::ST_WRITE;
                end
            end
            sacl_pkg::ST_WRITE: begin
                if (wr_fire) begin
                    state_next = sacl_pkg::ST_IDLE;
                end
            end
            default: state_next = sacl_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        clr_addr_next   = clr_addr_reg;
        set_next        = set_reg;
        tag_next        = tag_reg;
        way_next        = way_reg;
        inv_way_next    = inv_way_reg;
        have_inv_next   = have_inv_reg;
        best_way_next   = best_way_reg;
        best_stamp_next = best_stamp_reg;
        have_best_next  = have_best_reg;
        victim_next     = victim_reg;
        hit_next        = hit_reg;
        cold_next       = cold_reg;
        time_next       = time_reg;
        miss_next       = miss_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_hit_next    = out_hit_reg;
        out_way_next    = out_way_reg;
        out_cold_next   = out_cold_reg;
        out_miss_next   = out_miss_reg;
        ram_we          = 1'b0;
        ram_waddr       = clr_addr_reg;
        ram_wdata       = '0;
        ram_raddr       = line_addr(way_reg + WAY_W'(1), set_reg);

        unique case (state_reg)
            sacl_pkg::ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + LINE_AW'(1);
            end
            sacl_pkg::ST_IDLE: begin
                if (in_fire) begin
                    set_next       = IDX_W'(baddr & set_mask);
                    tag_next       = baddr >> eff_ib;
                    way_next       = '0;
                    have_inv_next  = 1'b0;
                    have_best_next = 1'b0;
                end
            end
            sacl_pkg::ST_LOOKUP: begin
                ram_raddr = line_addr('0, set_reg);
            end
            sacl_pkg::ST_SCAN: begin
                if (!ram_rdata.valid && !have_inv_reg) begin
                    inv_way_next  = way_reg;
                    have_inv_next = 1'b1;
                end
                if (take_best) begin
                    best_way_next   = way_reg;
                    best_stamp_next = ram_rdata.stamp;
                    have_best_next  = 1'b1;
                end
                way_next  = way_reg + WAY_W'(1);
                hit_next  = match;
                cold_next = !match && have_inv_next;
                if (match) begin
                    victim_next = way_reg;
                end else if (have_inv_next) begin
                    victim_next = inv_way_next;
                end else begin
                    victim_next = best_way_next;
                end
            end
            sacl_pkg::ST_WRITE: begin
                if (wr_fire) begin
                    ram_we          = 1'b1;
                    ram_waddr       = line_addr(victim_reg, set_reg);
                    ram_wdata.valid = 1'b1;
                    ram_wdata.tag   = tag_reg;
                    ram_wdata.stamp = time_reg;
                    time_next       = time_reg + 32'd1;
                    miss_next       = hit_reg ? miss_reg : miss_reg + 32'd1;
                    out_valid_next  = 1'b1;
                    out_hit_next    = hit_reg;
                    out_way_next    = 2'(victim_reg);
                    out_cold_next   = cold_reg;
                    out_miss_next   = hit_reg ? miss_reg : miss_reg + 32'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sacl_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            time_reg      <= '0;
            miss_reg      <= '0;
            out_valid_reg <= 1'b0;
            have_inv_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            way_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            time_reg      <= time_next;
            miss_reg      <= miss_next;
            out_valid_reg <= out_valid_next;
            have_inv_reg  <= have_inv_next;
            have_best_reg <= have_best_next;
            way_reg       <= way_next;
        end
    end

    always_ff @(posedge aclk) begin
        set_reg        <= set_next;
        tag_reg        <= tag_next;
        inv_way_reg    <= inv_way_next;
        best_way_reg   <= best_way_next;
        best_stamp_reg <= best_stamp_next;
        victim_reg     <= victim_next;
        hit_reg        <= hit_next;
        cold_reg       <= cold_next;
        out_hit_reg    <= out_hit_next;
        out_way_reg    <= out_way_next;
        out_cold_reg   <= out_cold_next;
        out_miss_reg   <= out_miss_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_miss_reg, out_cold_reg, out_way_reg, out_hit_reg};

endmodule
